[rtl/core/dqcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqcr_pkg
// Shared types, constants and helper functions of the dual quadrature
// counter reporter.
// ----------------------------------------------------------------------------
package dqcr_pkg;

   // field widths
   localparam int PINS_W     = 4;
   localparam int SW_W       = 2;
   localparam int LIMIT_W    = 15;
   localparam int BYTE_W     = 8;
   localparam int CNT_W      = 16;
   localparam int PHASE_W    = 2;
   localparam int PKT_LEN    = 6;
   localparam int IDX_W      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // reset values
   localparam logic [LIMIT_W-1:0] ARM_LIMIT_RESET = 15'd2000;
   localparam logic [BYTE_W-1:0]  HEADER_RESET    = 8'h0A;
   localparam logic [CNT_W-1:0]   MOTOR_RESET     = 16'hEA60;

   // item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // register indexes (paddr word select)
   localparam logic REG_ARM_LIMIT = 1'b0;
   localparam logic REG_HEADER    = 1'b1;

   // decoder moves
   localparam logic [1:0] MOVE_NONE = 2'd0;
   localparam logic [1:0] MOVE_UP   = 2'd1;
   localparam logic [1:0] MOVE_DOWN = 2'd2;

   // packet byte positions
   localparam logic [IDX_W-1:0] IDX_HEADER  = 3'd0;
   localparam logic [IDX_W-1:0] IDX_ARM_HI  = 3'd1;
   localparam logic [IDX_W-1:0] IDX_ARM_LO  = 3'd2;
   localparam logic [IDX_W-1:0] IDX_MOT_HI  = 3'd3;
   localparam logic [IDX_W-1:0] IDX_MOT_LO  = 3'd4;
   localparam logic [IDX_W-1:0] IDX_SWITCH  = 3'd5;

   typedef struct packed {
      logic [LIMIT_W-1:0] arm_wrap_limit;
      logic [BYTE_W-1:0]  header_byte;
   } cfg_type;

   // snapshot taken on a report tick
   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [CNT_W-1:0]  arm_count;
      logic [CNT_W-1:0]  motor_count;
      logic [SW_W-1:0]   switch_bits;
   } report_type;

   // clockwise order B:A is 00 -> 10 -> 11 -> 01 -> 00
   function automatic logic [PHASE_W-1:0] cw_pred(input logic [PHASE_W-1:0] phase);
      logic [PHASE_W-1:0] pred;
      case (phase)
         2'b00:   pred = 2'b01;
         2'b01:   pred = 2'b11;
         2'b10:   pred = 2'b00;
         2'b11:   pred = 2'b10;
         default: pred = 2'b00;
      endcase
      return pred;
   endfunction

   // any other change, including a two-step jump, counts down
   function automatic logic [1:0] phase_move(input logic [PHASE_W-1:0] prev_phase,
                                             input logic [PHASE_W-1:0] cur_phase);
      logic [1:0] move;
      if (prev_phase == cur_phase) begin
         move = MOVE_NONE;
      end else if (cw_pred(cur_phase) == prev_phase) begin
         move = MOVE_UP;
      end else begin
         move = MOVE_DOWN;
      end
      return move;
   endfunction

   function automatic logic [BYTE_W-1:0] packet_byte(input report_type rpt,
                                                     input logic [IDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         IDX_HEADER: b = rpt.header_byte;
         IDX_ARM_HI: b = rpt.arm_count[CNT_W-1:BYTE_W];
         IDX_ARM_LO: b = rpt.arm_count[BYTE_W-1:0];
         IDX_MOT_HI: b = rpt.motor_count[CNT_W-1:BYTE_W];
         IDX_MOT_LO: b = rpt.motor_count[BYTE_W-1:0];
         IDX_SWITCH: b = {{(BYTE_W-SW_W){1'b0}}, rpt.switch_bits};
         default:    b = '0;
      endcase
      return b;
   endfunction

endpackage

[rtl/core/dqcr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqcr_if
// Valid/ready channel interfaces: request items in, packet bytes out.
// ----------------------------------------------------------------------------
interface dqcr_req_if;
   import dqcr_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [PINS_W-1:0] encoder_pins;
   logic [SW_W-1:0]   switch_bits;

   modport source (output valid, output kind, output encoder_pins,
                   output switch_bits, input ready);
   modport sink   (input valid, input kind, input encoder_pins,
                   input switch_bits, output ready);
endinterface

interface dqcr_rsp_if;
   import dqcr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

[rtl/core/dual_quadrature_counter_reporter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_quadrature_counter_reporter
// Two x4 quadrature counters (arm, motor) with a six-byte packet reporter.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one transaction per clock when ready: kind 0 is a 4-bit pin
//   sample (arm phase in bits 3:2, motor phase in bits 1:0), kind 1 a report tick.
//   Samples update the counts in the cycle they are taken, so one sample per
//   cycle is sustained. A tick snapshots header, counts and switch bits into
//   a QUEUE_DEPTH-entry queue; req_ch.ready drops only while that queue is full.
//   rsp_ch returns the packet: header, arm hi/lo, motor hi/lo, switches, with
//   last on the sixth byte. A tick is queued, then its first byte is loaded into
//   the output register when the output is idle; a packet streams one byte per
//   cycle while rsp_ch.ready is high; back-to-back packets follow with no idle
//   cycle between them (the byte serializer sets the sustained tick rate).
//   A stalled rsp_ch holds its byte; samples keep flowing until the queue fills.
//   Reset (synchronous) clears counts to 0 and 60000, previous pins to 0,
//   the limit to 2000 and the header to 0x0A, and empties the queue.
//   The CSR port writes register 0 (arm wrap limit) at 0x0 and register 1
//   (header byte) at 0x4; write only while no packet is pending.
// ----------------------------------------------------------------------------
module dual_quadrature_counter_reporter #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   dqcr_req_if.sink                         req_ch,
   dqcr_rsp_if.source                       rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dqcr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dqcr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [dqcr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import dqcr_pkg::*;

   cfg_type    cfg;
   report_type push_data;
   report_type head;
   logic       push;
   logic       pop;
   logic       queue_full;
   logic       head_valid;

   dqcr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dqcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   dqcr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .not_empty (head_valid)
   );

   dqcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

[rtl/core/dqcr_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqcr_csr
// APB-style register file: arm wrap limit and packet header byte.
// ----------------------------------------------------------------------------
module dqcr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dqcr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dqcr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dqcr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output dqcr_pkg::cfg_type                   cfg
);
   import dqcr_pkg::*;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [BYTE_W-1:0]  header_ff, header_in;
   logic               wr_en;
   logic               reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[CSR_ADDR_W-1];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // write decode
   always_comb begin
      limit_in  = limit_ff;
      header_in = header_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ARM_LIMIT: limit_in  = csr_pwdata[LIMIT_W-1:0];
            REG_HEADER:    header_in = csr_pwdata[BYTE_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= ARM_LIMIT_RESET;
         header_ff <= HEADER_RESET;
      end else begin
         limit_ff  <= limit_in;
         header_ff <= header_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_ARM_LIMIT: csr_prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, limit_ff};
         REG_HEADER:    csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, header_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.arm_wrap_limit = limit_ff;
   assign cfg.header_byte    = header_ff;

endmodule

[rtl/core/dqcr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqcr_front
// Accepts items, runs both quadrature decoders on pin samples and queues a
// count snapshot on each report tick.
// ----------------------------------------------------------------------------
module dqcr_front (
   input  logic                 clock,
   input  logic                 reset,
   dqcr_req_if.sink             req_ch,
   input  dqcr_pkg::cfg_type    cfg,
   input  logic                 queue_full,
   output logic                 push,
   output dqcr_pkg::report_type push_data
);
   import dqcr_pkg::*;

   logic [PINS_W-1:0] prev_pins_ff, prev_pins_in;
   logic [CNT_W-1:0]  arm_ff, arm_in;
   logic [CNT_W-1:0]  motor_ff, motor_in;
   logic              accept;
   logic [1:0]        arm_move;
   logic [1:0]        motor_move;
   logic [CNT_W:0]    arm_step;

   assign req_ch.ready = ~queue_full;
   assign accept       = req_ch.valid & ~queue_full;

   assign arm_move   = phase_move(prev_pins_ff[3:2], req_ch.encoder_pins[3:2]);
   assign motor_move = phase_move(prev_pins_ff[1:0], req_ch.encoder_pins[1:0]);

   // arm count one step away, sign-extended
   assign arm_step = (arm_move == MOVE_UP) ? ({arm_ff[CNT_W-1], arm_ff} + 17'd1)
                                           : ({arm_ff[CNT_W-1], arm_ff} - 17'd1);

   // decoder update
   always_comb begin
      prev_pins_in = prev_pins_ff;
      arm_in       = arm_ff;
      motor_in     = motor_ff;
      if (accept && req_ch.kind == KIND_SAMPLE) begin
         prev_pins_in = req_ch.encoder_pins;
         if (arm_move != MOVE_NONE) begin
            if (arm_step[CNT_W]) begin
               arm_in = {1'b0, cfg.arm_wrap_limit};
            end else if (arm_step[CNT_W-1:0] > {1'b0, cfg.arm_wrap_limit}) begin
               arm_in = '0;
            end else begin
               arm_in = arm_step[CNT_W-1:0];
            end
         end
         case (motor_move)
            MOVE_UP:   motor_in = motor_ff + 16'd1;
            MOVE_DOWN: motor_in = motor_ff - 16'd1;
            default:   motor_in = motor_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= '0;
         arm_ff       <= '0;
         motor_ff     <= MOTOR_RESET;
      end else begin
         prev_pins_ff <= prev_pins_in;
         arm_ff       <= arm_in;
         motor_ff     <= motor_in;
      end
   end

   // report snapshot into the queue
   assign push                  = accept & (req_ch.kind == KIND_TICK);
   assign push_data.header_byte = cfg.header_byte;
   assign push_data.arm_count   = arm_ff;
   assign push_data.motor_count = motor_ff;
   assign push_data.switch_bits = req_ch.switch_bits;

endmodule

[rtl/core/dqcr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqcr_queue
// Small flip-flop FIFO of report snapshots between front and back.
// ----------------------------------------------------------------------------
module dqcr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dqcr_pkg::report_type push_data,
   output logic                 full,
   input  logic                 pop,
   output dqcr_pkg::report_type head,
   output logic                 not_empty
);
   import dqcr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   report_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_QW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/dqcr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqcr_back
// Serializes each queued snapshot into six packet bytes behind an output
// register.
// ----------------------------------------------------------------------------
module dqcr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dqcr_pkg::report_type head,
   input  logic                 head_valid,
   output logic                 pop,
   dqcr_rsp_if.source           rsp_ch
);
   import dqcr_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_LEN - 1);

   report_type        pkt_ff, pkt_in;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              advance;

   // output register is free or being drained
   assign advance = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      pkt_in       = pkt_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      if (advance) begin
         if (busy_ff) begin
            // next byte of the current packet
            rsp_valid_in = 1'b1;
            rsp_byte_in  = packet_byte(pkt_ff, idx_ff);
            rsp_last_in  = (idx_ff == LAST_IDX);
            idx_in       = idx_ff + 1'b1;
            busy_in      = (idx_ff != LAST_IDX);
         end else if (head_valid) begin
            // start a packet straight from the queue head
            pop          = 1'b1;
            pkt_in       = head;
            rsp_valid_in = 1'b1;
            rsp_byte_in  = packet_byte(head, IDX_HEADER);
            rsp_last_in  = 1'b0;
            idx_in       = IDX_ARM_HI;
            busy_in      = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= IDX_HEADER;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff      <= pkt_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = rsp_byte_ff;
   assign rsp_ch.last     = rsp_last_ff;

endmodule

[rtl/core/dqcr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqcr_checker
// Port-level checks of the counter reporter, bound to the top level.
// ----------------------------------------------------------------------------
module dqcr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [dqcr_pkg::BYTE_W-1:0]      rsp_out_byte,
   input  logic                             rsp_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dqcr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dqcr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic [dqcr_pkg::CSR_DATA_W-1:0]  csr_prdata
);
   import dqcr_pkg::*;

   logic hdr_write;
   logic hdr_read;

   assign hdr_write = csr_psel & csr_penable & csr_pwrite & csr_paddr[CSR_ADDR_W-1];
   assign hdr_read  = csr_psel & ~csr_pwrite & csr_paddr[CSR_ADDR_W-1];

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("rsp byte changed while stalled");

   // packet bytes stream without gaps
   a_pkt_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a packet");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // header register reads back what was just written
   a_hdr_readback: assert property (@(posedge clock) disable iff (reset)
      hdr_write ##1 hdr_read |-> csr_prdata[BYTE_W-1:0] == $past(csr_pwdata[BYTE_W-1:0]))
      else $error("header readback mismatch");

endmodule

bind dual_quadrature_counter_reporter dqcr_checker u_dqcr_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_out_byte (rsp_ch.out_byte),
   .rsp_last     (rsp_ch.last),
   .csr_psel     (csr_psel),
   .csr_penable  (csr_penable),
   .csr_pwrite   (csr_pwrite),
   .csr_paddr    (csr_paddr),
   .csr_pwdata   (csr_pwdata),
   .csr_prdata   (csr_prdata)
);
